// ===== src/rwol_pkg.sv =====
// ----------------------------------------------------------------------------
// rwol_pkg
// shared types and constants of the write record ring with offset lookup
// ----------------------------------------------------------------------------
package rwol_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int HANDLE_W = 32;
    localparam int LENGTH_W = 20;
    localparam int OFFSET_W = 24;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [HANDLE_W-1:0] entry_handle;
        logic [LENGTH_W-1:0] entry_length;
        logic [OFFSET_W-1:0] char_pos;
    } t_in_req;

    typedef struct packed {
        logic                found;
        logic [HANDLE_W-1:0] found_handle;
        logic [LENGTH_W-1:0] offset_in_entry;
    } t_out_rsp;

endpackage

// ===== src/rwol_ram.sv =====
// ----------------------------------------------------------------------------
// rwol_ram
// generic simple dual port ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module rwol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/ring_of_write_records_offset_lookup.sv =====
// ----------------------------------------------------------------------------
// ring_of_write_records_offset_lookup
// ring of write records (handle, byte length) with character offset lookup
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry one request in i_in_data.
//   mode add stores a record at the write index, overwriting the oldest
//   record once the ring is full. mode find walks the records oldest to
//   newest as one byte stream and reports the record holding char_pos.
// output channel: o_out_valid / i_out_stall carry exactly one response per
//   request in o_out_data, in request order.
// timing: an add goes from acceptance straight to the emit state. a find
//   visits stored records until a hit, at most RING_DEPTH of them. the
//   walk reads one record per cycle through the single read port of the
//   record memory. a new request is taken once the previous response sits
//   in the output register.
// reset: indices and the full flag clear, so the ring is empty; the record
//   memory keeps its contents and is not cleared.
// stall: while i_out_stall holds a response, the block finishes at most one
//   more request and then raises o_in_stall until the output drains.
// ----------------------------------------------------------------------------
module ring_of_write_records_offset_lookup #(
    parameter int RING_DEPTH = rwol_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rwol_pkg::t_in_req i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rwol_pkg::t_out_rsp o_out_data
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int DATA_W = rwol_pkg::HANDLE_W + rwol_pkg::LENGTH_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_write_index;
    logic [IDX_W-1:0]              r_read_index;
    logic                          r_ring_full;
    logic [IDX_W-1:0]              r_slot;
    logic [rwol_pkg::OFFSET_W-1:0] r_total;
    logic [rwol_pkg::OFFSET_W-1:0] r_target;
    rwol_pkg::t_out_rsp            r_res;
    logic                          r_out_valid;
    rwol_pkg::t_out_rsp            r_out_data;

    logic                          in_accept;
    logic                          out_free;
    logic                          emit_now;
    logic                          ring_empty;
    logic [IDX_W-1:0]              n_write_index;
    logic [IDX_W-1:0]              n_read_index;
    logic [IDX_W-1:0]              slot_next;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_raddr;
    logic [DATA_W-1:0]             ram_wdata;
    logic [DATA_W-1:0]             ram_rdata;
    logic [rwol_pkg::HANDLE_W-1:0] rd_handle;
    logic [rwol_pkg::LENGTH_W-1:0] rd_length;
    logic [rwol_pkg::OFFSET_W:0]   sum;
    logic                          hit;
    logic [rwol_pkg::OFFSET_W-1:0] diff;
    logic                          walk_end;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit_now    = (r_state == S_EMIT) && out_free;
    assign ring_empty  = (r_write_index == r_read_index) && !r_ring_full;

    assign n_write_index = (r_write_index == IDX_W'(RING_DEPTH - 1)) ?
                           '0 : r_write_index + 1'b1;
    assign n_read_index  = r_ring_full ? n_write_index : r_read_index;
    assign slot_next     = (r_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    assign ram_we    = in_accept && (i_in_data.mode == rwol_pkg::MODE_ADD);
    assign ram_wdata = {i_in_data.entry_handle, i_in_data.entry_length};
    assign ram_raddr = (r_state == S_WALK) ? slot_next : r_read_index;

    rwol_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_write_index),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_handle = ram_rdata[DATA_W-1:rwol_pkg::LENGTH_W];
    assign rd_length = ram_rdata[rwol_pkg::LENGTH_W-1:0];
    assign sum       = {1'b0, r_total} + (rwol_pkg::OFFSET_W + 1)'(rd_length);
    assign hit       = sum > {1'b0, r_target};
    assign diff      = r_target - r_total;
    // full ring returns to the write index after visiting every slot too
    assign walk_end  = (slot_next == r_write_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_write_index <= '0;
            r_read_index  <= '0;
            r_ring_full   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (emit_now) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_res    <= '0;
                        r_target <= i_in_data.char_pos;
                        r_total  <= '0;
                        r_slot   <= r_read_index;
                        if (i_in_data.mode == rwol_pkg::MODE_ADD) begin
                            r_write_index <= n_write_index;
                            r_read_index  <= n_read_index;
                            r_ring_full   <= (n_write_index == n_read_index);
                            r_state       <= S_EMIT;
                        end else if (ring_empty) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (hit) begin
                        r_res.found           <= 1'b1;
                        r_res.found_handle    <= rd_handle;
                        r_res.offset_in_entry <= diff[rwol_pkg::LENGTH_W-1:0];
                        r_state               <= S_EMIT;
                    end else begin
                        r_total <= sum[rwol_pkg::OFFSET_W-1:0];
                        r_slot  <= slot_next;
                        if (walk_end) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== dv/rwol_checker.sv =====
// ----------------------------------------------------------------------------
// rwol_checker
// watches both channels of the record ring, predicts each response from its
// own copy of the ring and compares it with what the block hands out
// ----------------------------------------------------------------------------
module rwol_checker #(
    parameter int RING_DEPTH = rwol_pkg::RING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  rwol_pkg::t_in_req  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  rwol_pkg::t_out_rsp i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [rwol_pkg::HANDLE_W-1:0] handle_mem [RING_DEPTH];
    logic [rwol_pkg::LENGTH_W-1:0] length_mem [RING_DEPTH];
    int unsigned                   wr_ptr;
    int unsigned                   rd_ptr;
    bit                            ring_full;
    rwol_pkg::t_out_rsp            rsp_due_q [$];
    int                            mismatches = 0;

    // applies one request to the ring copy and returns the response it owes
    function automatic rwol_pkg::t_out_rsp apply_request(rwol_pkg::t_in_req req);
        rwol_pkg::t_out_rsp rsp;
        int unsigned        slot;
        int unsigned        stream_pos;
        rsp = '0;
        if (req.mode == rwol_pkg::MODE_ADD) begin
            handle_mem[wr_ptr] = req.entry_handle;
            length_mem[wr_ptr] = req.entry_length;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (ring_full) begin
                rd_ptr = wr_ptr;
            end
            ring_full = (wr_ptr == rd_ptr);
            return rsp;
        end
        slot       = rd_ptr;
        stream_pos = 0;
        for (int n = 0; n < RING_DEPTH; n++) begin
            if (slot == wr_ptr && !ring_full) begin
                break;
            end
            if (stream_pos + length_mem[slot] > req.char_pos) begin
                rsp.found           = 1'b1;
                rsp.found_handle    = handle_mem[slot];
                rsp.offset_in_entry = rwol_pkg::LENGTH_W'(req.char_pos - stream_pos);
                return rsp;
            end
            stream_pos += length_mem[slot];
            slot = (slot + 1) % RING_DEPTH;
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        rwol_pkg::t_out_rsp exp_rsp;
        if (!i_rst_n) begin
            wr_ptr    = 0;
            rd_ptr    = 0;
            ring_full = 1'b0;
            rsp_due_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                rsp_due_q.push_back(apply_request(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (rsp_due_q.size() == 0) begin
                    $display("%0t unexpected response: found=%0b handle=%h offset=%h",
                             $time, i_out_data.found, i_out_data.found_handle,
                             i_out_data.offset_in_entry);
                    mismatches++;
                end else begin
                    exp_rsp = rsp_due_q.pop_front();
                    if (i_out_data !== exp_rsp) begin
                        $display("%0t mismatch: expected found=%0b handle=%h offset=%h",
                                 $time, exp_rsp.found, exp_rsp.found_handle,
                                 exp_rsp.offset_in_entry);
                        $display("%0t           actual   found=%0b handle=%h offset=%h",
                                 $time, i_out_data.found, i_out_data.found_handle,
                                 i_out_data.offset_in_entry);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rsp_due_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives add and find requests into the record ring with bursty traffic and
// a wandering output stall, and gives the verdict from the checker's count
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RING_DEPTH   = rwol_pkg::RING_DEPTH_DEF;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int unsigned LEN_MAX      = (1 << rwol_pkg::LENGTH_W) - 1;
    localparam int unsigned OFFSET_MAX   = (1 << rwol_pkg::OFFSET_W) - 1;
    localparam int unsigned HANDLE_MAX   = 32'hFFFF_FFFF;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_style;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    rwol_pkg::t_in_req  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    rwol_pkg::t_out_rsp o_out_data;

    int           fail_count;
    int           pending;
    int unsigned  len_hist [$];
    int           burst_left = 0;
    t_stall_style stall_style = STALL_NONE;
    int           stall_left  = 0;

    ring_of_write_records_offset_lookup #(
        .RING_DEPTH (RING_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    rwol_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // output stall wanders between styles, including stretches with none
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_left  <= $urandom_range(32, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 8);
            default:     i_out_stall <= ((stall_left % 5) < 2);
        endcase
    end

    // bytes currently held by the ring, for aiming find offsets
    function automatic int unsigned ring_span();
        int unsigned span;
        span = 0;
        foreach (len_hist[k]) begin
            span += len_hist[k];
        end
        return span;
    endfunction

    function automatic rwol_pkg::t_in_req make_req(logic mode, int unsigned handle,
                                                   int unsigned length,
                                                   int unsigned offset);
        rwol_pkg::t_in_req req;
        req.mode         = mode;
        req.entry_handle = rwol_pkg::HANDLE_W'(handle);
        req.entry_length = rwol_pkg::LENGTH_W'(length);
        req.char_pos     = rwol_pkg::OFFSET_W'(offset);
        return req;
    endfunction

    function automatic rwol_pkg::t_in_req pick_request(bit heavy);
        rwol_pkg::t_in_req req;
        int unsigned       span;
        int unsigned       target;
        span = ring_span();
        req.mode         = ($urandom_range(0, 99) < (heavy ? 70 : 40)) ?
                           rwol_pkg::MODE_ADD : rwol_pkg::MODE_FIND;
        req.entry_handle = $urandom;
        case ($urandom_range(0, 9))
            0:       req.entry_length = '0;
            1:       req.entry_length = rwol_pkg::LENGTH_W'($urandom);
            2:       req.entry_length = rwol_pkg::LENGTH_W'(LEN_MAX);
            default: req.entry_length = rwol_pkg::LENGTH_W'($urandom_range(1, 64));
        endcase
        // long records so the stream reaches the top of the offset range
        if (heavy) begin
            req.entry_length = rwol_pkg::LENGTH_W'($urandom_range(LEN_MAX - 255, LEN_MAX));
        end
        case ($urandom_range(0, 9))
            0:       target = $urandom & OFFSET_MAX;
            1:       target = span;
            2:       target = (span == 0) ? 0 : span - 1;
            default: target = $urandom_range(0, span + span / 8);
        endcase
        if (target > OFFSET_MAX) begin
            target = OFFSET_MAX;
        end
        req.char_pos = rwol_pkg::OFFSET_W'(target);
        return req;
    endfunction

    task automatic send_request(input rwol_pkg::t_in_req req);
        int gap;
        i_in_data  <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (req.mode == rwol_pkg::MODE_ADD) begin
            len_hist.push_back(req.entry_length);
            if (len_hist.size() > RING_DEPTH) begin
                void'(len_hist.pop_front());
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    initial begin
        int sent;
        int heavy_left;
        bit heavy;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty ring, zero-length record, record boundaries
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, 0));
        send_request(make_req(rwol_pkg::MODE_ADD, HANDLE_MAX, 0, OFFSET_MAX));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, 0));
        send_request(make_req(rwol_pkg::MODE_ADD, 0, LEN_MAX, 0));
        send_request(make_req(rwol_pkg::MODE_FIND, HANDLE_MAX, LEN_MAX, 0));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, LEN_MAX - 1));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, LEN_MAX));
        send_request(make_req(rwol_pkg::MODE_ADD, 32'hA5A5_5A5A, 1, 0));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, LEN_MAX));
        // fill the ring, then overwrite the oldest record
        repeat (RING_DEPTH - 3) begin
            send_request(make_req(rwol_pkg::MODE_ADD, $urandom, LEN_MAX, 0));
        end
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, ring_span() - 1));
        send_request(make_req(rwol_pkg::MODE_ADD, 32'h5A5A_A5A5, 7, 0));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, 0));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, ring_span() - 1));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, ring_span()));
        send_request(make_req(rwol_pkg::MODE_FIND, 0, 0, OFFSET_MAX));

        sent       = 0;
        heavy_left = 0;
        heavy      = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (heavy_left == 0) begin
                heavy      = ($urandom_range(0, 5) == 0);
                heavy_left = heavy ? 2 * RING_DEPTH : $urandom_range(20, 80);
            end
            send_request(pick_request(heavy));
            sent++;
            heavy_left--;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (RING_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rwol_pkg.sv
src/rwol_ram.sv
src/ring_of_write_records_offset_lookup.sv
dv/rwol_checker.sv
dv/tb_top.sv
